### sv/jdcd_pkg.sv
`timescale 1ns / 1ps
// jdcd_pkg: widths, division constants and the month start table for the
// julian day to calendar date pipeline. no dependencies.
package jdcd_pkg;

    // field widths
    localparam int IN_W    = 26;   // julian day in tenths
    localparam int JD_W    = 23;   // whole julian day
    localparam int TEN_W   = 4;    // tenths digit
    localparam int N1_W    = 25;   // 4*jd + bias, century numerator
    localparam int Q_W     = 8;    // biased century count
    localparam int B_W     = 23;   // shifted day count
    localparam int N2_W    = 25;   // 4*b - bias, year numerator
    localparam int C_W     = 15;   // year count
    localparam int X_W     = 9;    // day within year cycle
    localparam int E_W     = 4;    // month index
    localparam int R_W     = 16;   // 100*x
    localparam int MON_W   = 4;
    localparam int DOM_W   = 5;
    localparam int YR_W    = 14;
    localparam int YS_W    = 16;   // signed year

    // divide by 10: exact reciprocal for any 32-bit value
    localparam int DIV10_MUL_W = 32;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 32'hCCCC_CCCD;
    localparam int DIV10_SHIFT = 35;
    localparam logic [TEN_W-1:0] ROUND_UP_TENTH = 4'd5;

    // century term: floor((4*jd + 128179) / 146097) = ab + 52
    localparam logic [N1_W-1:0] CENT_BIAS = 25'd128179;
    localparam int CENT_MUL_W = 15;
    localparam logic [CENT_MUL_W-1:0] CENT_MUL = 15'd29398;
    localparam int CENT_SHIFT = 32;
    localparam logic [N1_W-1:0] CENT_DIV = 25'd146097;
    // b = jd + q - q/4 + 1486 (folds +1, -39 and +1524)
    localparam logic [B_W-1:0] B_BIAS = 23'd1486;

    // year term: c = floor((4*b - 489) / 1461)
    localparam logic [N2_W-1:0] YEAR_BIAS = 25'd489;
    localparam int YEAR_MUL_W = 22;
    localparam logic [YEAR_MUL_W-1:0] YEAR_MUL = 22'd2939744;
    localparam int YEAR_SHIFT = 32;
    localparam logic [N2_W-1:0] YEAR_DIV = 25'd1461;

    // month term: e = floor(100*x / 3061)
    localparam int MON_MUL_W = 16;
    localparam logic [MON_MUL_W-1:0] MON_MUL = 16'd34200;
    localparam int MON_SHIFT = 20;
    localparam logic [R_W-1:0] MON_DIV = 16'd3061;
    localparam logic [R_W-1:0] DAY_SCALE = 16'd100;

    localparam logic [E_W-1:0] E_WRAP = 4'd14;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [YS_W-1:0] YEAR_OFFSET = 16'd4716;
    localparam logic [YS_W-1:0] YEAR_EPOCH = 16'd1900;

    // floor(30.61 * e)
    function automatic logic [X_W-1:0] month_start(input logic [E_W-1:0] e);
        logic [X_W-1:0] v;
        case (e)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd397;
            4'd14:   v = 9'd428;
            4'd15:   v = 9'd459;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

### sv/julian_day_to_calendar_date_top.sv
`timescale 1ns / 1ps
// julian_day_to_calendar_date_top: julian day (tenths) to gregorian date.
// depends on jdcd_pkg, jdcd_round, jdcd_century, jdcd_cycle, jdcd_month.
//
// usage
//   - drive i_julian_day_tenths and raise i_start; a transaction is taken at
//     every rising edge where i_start is high and o_busy is low
//   - o_busy is high only while i_rst_n is low, so a new transaction can be
//     issued on every clock cycle
//   - each transaction returns one date: o_done pulses for exactly one cycle
//     with o_month, o_day_of_month and o_year_since_1900 valid in that cycle
//   - throughput is one date per cycle through the 14-stage pipeline of
//     reciprocal multiplies (divide by 10, 146097, 1461, 3061)
//   - the receiver cannot stall: results leave in issue order, one per
//     accepted transaction, with no backpressure path
//   - synchronous reset clears all stage valid bits; transactions in flight
//     are dropped, nothing else needs clearing
//   - the tenths digit rounds half up to a whole day before conversion
module julian_day_to_calendar_date_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [jdcd_pkg::IN_W-1:0]   i_julian_day_tenths,
    output logic                        o_done,
    output logic [jdcd_pkg::MON_W-1:0]  o_month,
    output logic [jdcd_pkg::DOM_W-1:0]  o_day_of_month,
    output logic [jdcd_pkg::YR_W-1:0]   o_year_since_1900
);
    logic                        accept;
    logic                        jd_vld, b_vld, cx_vld;
    logic [jdcd_pkg::JD_W-1:0]   jd;
    logic [jdcd_pkg::B_W-1:0]    b;
    logic [jdcd_pkg::C_W-1:0]    c;
    logic [jdcd_pkg::X_W-1:0]    x;

    // pipeline never blocks; only reset holds off new work
    assign o_busy = ~i_rst_n;
    assign accept = i_start & ~o_busy;

    // stages 1-3: capture, divide by ten, round half up
    jdcd_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_tenths (i_julian_day_tenths),
        .o_valid  (jd_vld),
        .o_jd     (jd)
    );

    // stages 4-7: century correction, b = jd + 1 + ab - ab/4 + 1524
    jdcd_century u_century (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (jd_vld),
        .i_jd    (jd),
        .o_valid (b_vld),
        .o_b     (b)
    );

    // stages 8-11: year count and day within the year
    jdcd_cycle u_cycle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (b_vld),
        .i_b     (b),
        .o_valid (cx_vld),
        .o_c     (c),
        .o_x     (x)
    );

    // stages 12-14: month, day, year fix-up into the output registers
    jdcd_month u_month (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (cx_vld),
        .i_c               (c),
        .i_x               (x),
        .o_valid           (o_done),
        .o_month           (o_month),
        .o_day_of_month    (o_day_of_month),
        .o_year_since_1900 (o_year_since_1900)
    );
endmodule

### sv/jdcd_round.sv
`timescale 1ns / 1ps
// jdcd_round: input capture, divide by ten and round to a whole day.
// depends on jdcd_pkg.
module jdcd_round (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [jdcd_pkg::IN_W-1:0]   i_tenths,
    output logic                        o_valid,
    output logic [jdcd_pkg::JD_W-1:0]   o_jd
);
    localparam int PROD_W = jdcd_pkg::IN_W + jdcd_pkg::DIV10_MUL_W;

    logic                        r_a_vld, r_b_vld, r_c_vld;
    logic [jdcd_pkg::IN_W-1:0]   r_a_raw, r_b_raw;
    logic [jdcd_pkg::JD_W-1:0]   r_b_whole, r_c_jd;

    logic [PROD_W-1:0]           n_prod;
    logic [jdcd_pkg::IN_W-1:0]   n_whole10, n_diff;
    logic [jdcd_pkg::TEN_W-1:0]  n_tenth;
    logic [jdcd_pkg::JD_W-1:0]   n_jd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    // reciprocal multiply, exact quotient
    assign n_prod = PROD_W'(r_a_raw) * PROD_W'(jdcd_pkg::DIV10_MUL);

    // tenths digit = raw - 10*whole
    assign n_whole10 = {r_b_whole, 3'b000} + {2'b00, r_b_whole, 1'b0};
    assign n_diff    = r_b_raw - n_whole10;
    assign n_tenth   = n_diff[jdcd_pkg::TEN_W-1:0];
    assign n_jd      = r_b_whole
                     + jdcd_pkg::JD_W'(n_tenth >= jdcd_pkg::ROUND_UP_TENTH);

    always_ff @(posedge i_clk) begin
        r_a_raw   <= i_tenths;
        r_b_raw   <= r_a_raw;
        r_b_whole <= n_prod[jdcd_pkg::DIV10_SHIFT +: jdcd_pkg::JD_W];
        r_c_jd    <= n_jd;
    end

    assign o_valid = r_c_vld;
    assign o_jd    = r_c_jd;
endmodule

### sv/jdcd_century.sv
`timescale 1ns / 1ps
// jdcd_century: gregorian century correction, gives the shifted day count b.
// depends on jdcd_pkg.
module jdcd_century (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [jdcd_pkg::JD_W-1:0]   i_jd,
    output logic                        o_valid,
    output logic [jdcd_pkg::B_W-1:0]    o_b
);
    localparam int PROD_W = jdcd_pkg::N1_W + jdcd_pkg::CENT_MUL_W;

    logic [3:0]                  r_vld;
    logic [jdcd_pkg::JD_W-1:0]   r_jd1, r_jd2, r_jd3;
    logic [jdcd_pkg::N1_W-1:0]   r_n1, r_n1b;
    logic [jdcd_pkg::Q_W-1:0]    r_q0, r_q;
    logic [jdcd_pkg::B_W-1:0]    r_b;

    logic [jdcd_pkg::N1_W-1:0]   n_n1, n_rem, n_qd;
    logic [PROD_W-1:0]           n_prod;
    logic [jdcd_pkg::Q_W-1:0]    n_q;
    logic [jdcd_pkg::B_W-1:0]    n_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    assign n_n1   = {i_jd, 2'b00} + jdcd_pkg::CENT_BIAS;
    assign n_prod = PROD_W'(r_n1) * PROD_W'(jdcd_pkg::CENT_MUL);

    // estimate is low by at most one
    assign n_qd  = jdcd_pkg::N1_W'(r_q0) * jdcd_pkg::CENT_DIV;
    assign n_rem = r_n1b - n_qd;
    assign n_q   = r_q0 + jdcd_pkg::Q_W'(n_rem >= jdcd_pkg::CENT_DIV);

    assign n_b = r_jd3 + jdcd_pkg::B_W'(r_q) - jdcd_pkg::B_W'(r_q >> 2)
               + jdcd_pkg::B_BIAS;

    always_ff @(posedge i_clk) begin
        r_n1  <= n_n1;
        r_jd1 <= i_jd;
        r_q0  <= n_prod[jdcd_pkg::CENT_SHIFT +: jdcd_pkg::Q_W];
        r_n1b <= r_n1;
        r_jd2 <= r_jd1;
        r_q   <= n_q;
        r_jd3 <= r_jd2;
        r_b   <= n_b;
    end

    assign o_valid = r_vld[3];
    assign o_b     = r_b;
endmodule

### sv/jdcd_cycle.sv
`timescale 1ns / 1ps
// jdcd_cycle: year count c and day within the year cycle x = b - floor(1461c/4).
// depends on jdcd_pkg.
module jdcd_cycle (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [jdcd_pkg::B_W-1:0]    i_b,
    output logic                        o_valid,
    output logic [jdcd_pkg::C_W-1:0]    o_c,
    output logic [jdcd_pkg::X_W-1:0]    o_x
);
    localparam int PROD_W = jdcd_pkg::N2_W + jdcd_pkg::YEAR_MUL_W;

    logic [3:0]                  r_vld;
    logic [jdcd_pkg::B_W-1:0]    r_b1, r_b2, r_b3;
    logic [jdcd_pkg::N2_W-1:0]   r_n2, r_n2b;
    logic [jdcd_pkg::C_W-1:0]    r_c0, r_c, r_c4;
    logic [jdcd_pkg::X_W-1:0]    r_x;

    logic [jdcd_pkg::N2_W-1:0]   n_n2, n_cd, n_rem, n_days;
    logic [PROD_W-1:0]           n_prod;
    logic [jdcd_pkg::C_W-1:0]    n_c;
    logic [jdcd_pkg::B_W-1:0]    n_xw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    assign n_n2   = {i_b, 2'b00} - jdcd_pkg::YEAR_BIAS;
    assign n_prod = PROD_W'(r_n2) * PROD_W'(jdcd_pkg::YEAR_MUL);

    assign n_cd  = jdcd_pkg::N2_W'(r_c0) * jdcd_pkg::YEAR_DIV;
    assign n_rem = r_n2b - n_cd;
    assign n_c   = r_c0 + jdcd_pkg::C_W'(n_rem >= jdcd_pkg::YEAR_DIV);

    // d = floor(1461*c/4), x = b - d
    assign n_days = jdcd_pkg::N2_W'(r_c) * jdcd_pkg::YEAR_DIV;
    assign n_xw   = r_b3 - n_days[jdcd_pkg::N2_W-1:2];

    always_ff @(posedge i_clk) begin
        r_n2  <= n_n2;
        r_b1  <= i_b;
        r_c0  <= n_prod[jdcd_pkg::YEAR_SHIFT +: jdcd_pkg::C_W];
        r_n2b <= r_n2;
        r_b2  <= r_b1;
        r_c   <= n_c;
        r_b3  <= r_b2;
        r_x   <= n_xw[jdcd_pkg::X_W-1:0];
        r_c4  <= r_c;
    end

    assign o_valid = r_vld[3];
    assign o_c     = r_c4;
    assign o_x     = r_x;
endmodule

### sv/jdcd_month.sv
`timescale 1ns / 1ps
// jdcd_month: month index, day of month and year fix-up, output registers.
// depends on jdcd_pkg.
module jdcd_month (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [jdcd_pkg::C_W-1:0]    i_c,
    input  logic [jdcd_pkg::X_W-1:0]    i_x,
    output logic                        o_valid,
    output logic [jdcd_pkg::MON_W-1:0]  o_month,
    output logic [jdcd_pkg::DOM_W-1:0]  o_day_of_month,
    output logic [jdcd_pkg::YR_W-1:0]   o_year_since_1900
);
    localparam int PROD_W = jdcd_pkg::X_W + jdcd_pkg::MON_MUL_W;

    logic [2:0]                  r_vld;
    logic [jdcd_pkg::C_W-1:0]    r_c1, r_c2;
    logic [jdcd_pkg::X_W-1:0]    r_x1, r_x2;
    logic [jdcd_pkg::E_W-1:0]    r_e0, r_e;
    logic [jdcd_pkg::MON_W-1:0]  r_month;
    logic [jdcd_pkg::DOM_W-1:0]  r_dom;
    logic [jdcd_pkg::YR_W-1:0]   r_year;

    logic [PROD_W-1:0]           n_prod;
    logic [jdcd_pkg::R_W-1:0]    n_x100, n_ed, n_rem;
    logic [jdcd_pkg::E_W-1:0]    n_e;
    logic [jdcd_pkg::MON_W-1:0]  n_month;
    logic [jdcd_pkg::X_W-1:0]    n_domw;
    logic [jdcd_pkg::YS_W-1:0]   n_yr0, n_yr;
    logic [jdcd_pkg::YR_W-1:0]   n_year;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    assign n_prod = PROD_W'(i_x) * PROD_W'(jdcd_pkg::MON_MUL);

    assign n_x100 = jdcd_pkg::R_W'(r_x1) * jdcd_pkg::DAY_SCALE;
    assign n_ed   = jdcd_pkg::R_W'(r_e0) * jdcd_pkg::MON_DIV;
    assign n_rem  = n_x100 - n_ed;
    assign n_e    = r_e0 + jdcd_pkg::E_W'(n_rem >= jdcd_pkg::MON_DIV);

    // e counts from march; january and february wrap into the next year
    always_comb begin
        n_month = r_e - 4'd1;
        if (r_e >= jdcd_pkg::E_WRAP) begin
            n_month = r_e - 4'd13;
        end
        n_domw = r_x2 - jdcd_pkg::month_start(r_e);
        n_yr0  = jdcd_pkg::YS_W'(r_c2) - jdcd_pkg::YEAR_OFFSET
               + jdcd_pkg::YS_W'(n_month <= jdcd_pkg::MON_FEB);
        n_yr   = n_yr0;
        if ($signed(n_yr0) > $signed(jdcd_pkg::YEAR_EPOCH)) begin
            n_yr = n_yr0 - jdcd_pkg::YEAR_EPOCH;
        end
        if (n_yr0[jdcd_pkg::YS_W-1]) begin
            n_yr = '0;
        end
        n_year = n_yr[jdcd_pkg::YR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_e0    <= n_prod[jdcd_pkg::MON_SHIFT +: jdcd_pkg::E_W];
        r_x1    <= i_x;
        r_c1    <= i_c;
        r_e     <= n_e;
        r_x2    <= r_x1;
        r_c2    <= r_c1;
        r_month <= n_month;
        r_dom   <= n_domw[jdcd_pkg::DOM_W-1:0];
        r_year  <= n_year;
    end

    assign o_valid           = r_vld[2];
    assign o_month           = r_month;
    assign o_day_of_month    = r_dom;
    assign o_year_since_1900 = r_year;
endmodule

### sv/jdcd_checker.sv
`timescale 1ns / 1ps
// jdcd_checker: port-level checks on latency and result ranges, bound to the top.
// depends on jdcd_pkg and julian_day_to_calendar_date_top.
module jdcd_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        o_busy,
    input  logic                        o_done,
    input  logic [jdcd_pkg::MON_W-1:0]  o_month,
    input  logic [jdcd_pkg::DOM_W-1:0]  o_day_of_month,
    input  logic [jdcd_pkg::YR_W-1:0]   o_year_since_1900
);
    // every accepted transaction must come out on o_done at the end of the pipeline
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##14 o_done)
        else $error("transaction did not complete after 14 cycles");

    // no result without a matching accepted transaction earlier
    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, 14))
        else $error("result without matching transaction");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_month >= 4'd1 && o_month <= 4'd12))
        else $error("month out of range");

    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_day_of_month >= 5'd1 && o_year_since_1900 <= 14'd13662))
        else $error("day or year out of range");
endmodule

bind julian_day_to_calendar_date_top jdcd_checker u_jdcd_checker (.*);

### sim/julian_day_to_calendar_date_top_tb.sv
`timescale 1ns / 1ps
// julian_day_to_calendar_date_top_tb: self-checking bench for the julian day
// (tenths) to gregorian date pipeline, with its own date predictor.
// depends on jdcd_pkg and julian_day_to_calendar_date_top.
module julian_day_to_calendar_date_top_tb;

    localparam int IN_W  = jdcd_pkg::IN_W;
    localparam int MON_W = jdcd_pkg::MON_W;
    localparam int DOM_W = jdcd_pkg::DOM_W;
    localparam int YR_W  = jdcd_pkg::YR_W;

    // clock and run length
    localparam time HALF_PERIOD   = 4ns;
    localparam int  RESET_CYCLES  = 9;
    localparam int  RANDOM_DATES  = 1700;
    localparam int  MAX_GAP       = 17;
    localparam int  SETTLE_CYCLES = 40;       // longer than the pipeline, leave margin
    localparam int  CYCLE_LIMIT   = 200000;   // watchdog bound for the whole run
    localparam int  REPORT_LIMIT  = 10;

    // largest legal input and largest whole day that still leaves room for a digit
    localparam logic [IN_W-1:0] TENTHS_MAX = {IN_W{1'b1}};
    localparam int  TOP_WHOLE_DAY = 6710885;

    // gregorian conversion constants, the decimals held as exact fractions
    localparam longint CENT_SCALE  = 64'sd400000;                   // 4 * 100000
    localparam longint CENT_OFFSET = 64'sd5112264 * 64'sd146097;    // 51.12264
    localparam longint CENT_DIV    = 64'sd146097 * 64'sd100000;     // 36524.25
    localparam longint CYC_SCALE   = 64'sd40000;                    // 4 * 10000
    localparam longint CYC_OFFSET  = 64'sd3343 * 64'sd1461;         // 0.3343
    localparam longint CYC_DIV     = 64'sd1461 * 64'sd10000;        // 365.25
    localparam longint DAYS_4YR    = 64'sd1461;
    localparam longint MON_NUM     = 64'sd3061;                     // 30.61
    localparam longint DAY_SHIFT   = 64'sd1524;
    localparam longint YEAR_SHIFT  = 64'sd4716;
    localparam longint EPOCH_YEAR  = 64'sd1900;

    // one predicted date, with the transaction that caused it for reports
    typedef struct packed {
        logic [IN_W-1:0]  tenths;
        logic [MON_W-1:0] month;
        logic [DOM_W-1:0] dom;
        logic [YR_W-1:0]  year;
    } cal_date_t;

    // directed vector: a date is typed in only where it is plain at a glance
    typedef struct packed {
        logic [IN_W-1:0]  tenths;
        logic             known;
        logic [MON_W-1:0] month;
        logic [DOM_W-1:0] dom;
        logic [YR_W-1:0]  year;
    } date_vector_t;

    localparam int NUM_VECTORS = 22;
    localparam date_vector_t DATE_VECTORS [NUM_VECTORS] = '{
        // day zero is 24 nov 4714 bc, year clamped to zero
        '{tenths: 26'd0,        known: 1'b1, month: 4'd11, dom: 5'd24, year: 14'd0},
        '{tenths: 26'd4,        known: 1'b1, month: 4'd11, dom: 5'd24, year: 14'd0},
        // tenths digit of five rounds up to day one
        '{tenths: 26'd5,        known: 1'b1, month: 4'd11, dom: 5'd25, year: 14'd0},
        '{tenths: 26'd9,        known: 1'b1, month: 4'd11, dom: 5'd25, year: 14'd0},
        '{tenths: 26'd10,       known: 1'b0, month: '0, dom: '0, year: '0},
        '{tenths: 26'd15,       known: 1'b0, month: '0, dom: '0, year: '0},
        // top of the input range, all ones, and the rounding digits below it
        '{tenths: TENTHS_MAX,   known: 1'b0, month: '0, dom: '0, year: '0},
        '{tenths: 26'd67108859, known: 1'b0, month: '0, dom: '0, year: '0},
        '{tenths: 26'd67108855, known: 1'b0, month: '0, dom: '0, year: '0},
        '{tenths: 26'd67108854, known: 1'b0, month: '0, dom: '0, year: '0},
        // around year zero, where the negative-year clamp lets go
        '{tenths: 26'd17210590, known: 1'b0, month: '0, dom: '0, year: '0},
        '{tenths: 26'd17210600, known: 1'b0, month: '0, dom: '0, year: '0},
        '{tenths: 26'd17213650, known: 1'b0, month: '0, dom: '0, year: '0},
        // 1582 reform, correction applied on both sides
        '{tenths: 26'd22991600, known: 1'b0, month: '0, dom: '0, year: '0},
        '{tenths: 26'd22991610, known: 1'b0, month: '0, dom: '0, year: '0},
        // 1899 / 1900 kept as plain years, 1901 offset
        '{tenths: 26'd24150200, known: 1'b0, month: '0, dom: '0, year: '0},
        '{tenths: 26'd24150210, known: 1'b0, month: '0, dom: '0, year: '0},
        '{tenths: 26'd24153860, known: 1'b0, month: '0, dom: '0, year: '0},
        // new year 2000 by rounding, leap day and the first of march
        '{tenths: 26'd24515440, known: 1'b0, month: '0, dom: '0, year: '0},
        '{tenths: 26'd24515445, known: 1'b0, month: '0, dom: '0, year: '0},
        '{tenths: 26'd24516040, known: 1'b0, month: '0, dom: '0, year: '0},
        '{tenths: 26'd24516050, known: 1'b0, month: '0, dom: '0, year: '0}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    logic [IN_W-1:0]  i_julian_day_tenths;
    logic             o_done;
    logic [MON_W-1:0] o_month;
    logic [DOM_W-1:0] o_day_of_month;
    logic [YR_W-1:0]  o_year_since_1900;

    // dates predicted for accepted transactions, oldest first
    cal_date_t pending_dates[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        no_idle_left;   // transactions left in the current back-to-back run

    julian_day_to_calendar_date_top uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .o_busy              (o_busy),
        .i_julian_day_tenths (i_julian_day_tenths),
        .o_done              (o_done),
        .o_month             (o_month),
        .o_day_of_month      (o_day_of_month),
        .o_year_since_1900   (o_year_since_1900)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // floor division for a positive divisor
    function automatic longint floor_quot(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    // expected date for one transaction
    function automatic cal_date_t predict_date(input logic [IN_W-1:0] tenths);
        longint    jd, ab, a, b, c, d, e, dom, mon, yr;
        cal_date_t r;
        // round half up to the whole day
        jd  = longint'(tenths) / 10;
        if (longint'(tenths) % 10 >= 5) begin
            jd = jd + 1;
        end
        // gregorian century correction, then the year and month terms
        ab  = floor_quot(CENT_SCALE * jd - CENT_OFFSET, CENT_DIV);
        a   = jd + 1 + ab - floor_quot(ab, 4);
        b   = a + DAY_SHIFT;
        c   = floor_quot(CYC_SCALE * b - CYC_OFFSET, CYC_DIV);
        d   = floor_quot(DAYS_4YR * c, 4);
        e   = floor_quot(100 * (b - d), MON_NUM);
        dom = b - d - floor_quot(MON_NUM * e, 100);
        mon = e - 1;
        yr  = c - YEAR_SHIFT;
        // months counted from march, wrap jan and feb into the next year
        if (e >= 14) begin
            mon = mon - 12;
        end
        if (mon <= 2) begin
            yr = yr + 1;
        end
        // offset only above 1900, negative years pinned at zero
        if (yr > EPOCH_YEAR) begin
            yr = yr - EPOCH_YEAR;
        end
        if (yr < 0) begin
            yr = 0;
        end
        r.tenths = tenths;
        r.month  = mon[MON_W-1:0];
        r.dom    = dom[DOM_W-1:0];
        r.year   = yr[YR_W-1:0];
        return r;
    endfunction

    // idle cycles before the next transaction; now and then a back-to-back run
    function automatic int next_gap();
        if (no_idle_left > 0) begin
            no_idle_left = no_idle_left - 1;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            no_idle_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // random input, weighted toward historic dates and the rounding digit
    function automatic logic [IN_W-1:0] random_tenths();
        logic [IN_W-1:0] v;
        int unsigned     whole;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                // anywhere in the 26-bit range
                v = IN_W'($urandom);
            end
            3, 4, 5, 6: begin
                // year 0 to about 3000
                whole = $urandom_range(1721000, 2817000);
                v = IN_W'(whole * 10 + $urandom_range(0, 9));
            end
            7: begin
                // either side of the round-up point
                whole = $urandom_range(0, TOP_WHOLE_DAY);
                v = IN_W'(whole * 10 + $urandom_range(4, 5));
            end
            8: begin
                // near the negative-year clamp
                whole = $urandom_range(1719000, 1723500);
                v = IN_W'(whole * 10 + $urandom_range(0, 9));
            end
            default: begin
                // the two ends of the input range
                if ($urandom_range(0, 1) == 0) begin
                    v = IN_W'($urandom_range(0, 5000));
                end else begin
                    v = TENTHS_MAX - IN_W'($urandom_range(0, 5000));
                end
            end
        endcase
        return v;
    endfunction

    // issue one transaction at a falling edge, hold it until the block takes it
    task automatic send_date(input logic [IN_W-1:0] tenths, input logic known,
                             input cal_date_t typed_date);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            // start low; junk on the data port must be ignored
            i_start             <= 1'b0;
            i_julian_day_tenths <= IN_W'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_start             <= 1'b1;
        i_julian_day_tenths <= tenths;
        @(posedge i_clk);
        while (o_busy) begin
            @(posedge i_clk);
        end
        // taken at this edge
        if (known) begin
            pending_dates.push_back(typed_date);
        end else begin
            pending_dates.push_back(predict_date(tenths));
        end
        @(negedge i_clk);
    endtask

    // stimulus
    initial begin : stimulus
        date_vector_t vec;
        cal_date_t    typed_date;

        i_rst_n             = 1'b0;
        i_start             = 1'b0;
        i_julian_day_tenths = '0;
        no_idle_left        = 0;

        // synchronous reset, released away from the rising edge
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed vectors
        for (int i = 0; i < NUM_VECTORS; i++) begin
            vec               = DATE_VECTORS[i];
            typed_date.tenths = vec.tenths;
            typed_date.month  = vec.month;
            typed_date.dom    = vec.dom;
            typed_date.year   = vec.year;
            send_date(vec.tenths, vec.known, typed_date);
        end

        // random transactions
        typed_date = '0;
        for (int i = 0; i < RANDOM_DATES; i++) begin
            send_date(random_tenths(), 1'b0, typed_date);
        end
        i_start <= 1'b0;

        // drain the pipeline, then give stray strobes a chance to show
        while (pending_dates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_dates.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // result checker: every strobe must match the oldest predicted date
    always @(posedge i_clk) begin : date_check
        cal_date_t want;
        if (i_rst_n && o_done) begin
            if (pending_dates.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < REPORT_LIMIT) begin
                    $display("unexpected result: month %0d day %0d year %0d",
                             o_month, o_day_of_month, o_year_since_1900);
                end
            end else begin
                want = pending_dates.pop_front();
                if (o_month !== want.month || o_day_of_month !== want.dom ||
                    o_year_since_1900 !== want.year) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("mismatch for tenths %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.tenths, want.month, want.dom, want.year,
                                 o_month, o_day_of_month, o_year_since_1900);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

endmodule

### julian_day_to_calendar_date_top.f
sv/jdcd_pkg.sv
sv/jdcd_round.sv
sv/jdcd_century.sv
sv/jdcd_cycle.sv
sv/jdcd_month.sv
sv/julian_day_to_calendar_date_top.sv
sv/jdcd_checker.sv
sim/julian_day_to_calendar_date_top_tb.sv
